// ===== design/esc_pkg.sv =====
`default_nettype none
package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_TRIM_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_TRIM_B   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam int DIV_STEPS = 32;

    localparam logic [31:0] K_64000    = 32'd64000;
    localparam logic [31:0] K_1048576  = 32'd1048576;
    localparam logic [31:0] K_3125     = 32'd3125;
    localparam logic [31:0] K_SIGN     = 32'h8000_0000;
    localparam logic [31:0] K_76800    = 32'd76800;
    localparam logic [31:0] K_HUM_MAX  = 32'd419430400;
    localparam logic [31:0] K_2097152  = 32'd2097152;
    localparam logic [31:0] K_16384    = 32'd16384;
    localparam logic [31:0] K_32768    = 32'd32768;
    localparam logic [31:0] K_8192     = 32'd8192;
    localparam logic [31:0] K_128      = 32'd128;

    // trim words, all widened to 32 bits
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_trim;

    // transaction between front and back
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [19:0] ap;
        logic [15:0] ah;
    } t_mid;

    // fields carried alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
        logic        dbl;
        logic        dzero;
    } t_side;

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        sx16 = {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        sx8 = {{24{x[7]}}, x};
    endfunction

endpackage
`default_nettype wire

// ===== design/esc_if.sv =====
`default_nettype none
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
    modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
    modport sink (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temp_centi;
    logic [31:0]        press_pa;
    logic [16:0]        hum_q10;
    logic signed [31:0] fine_temp;
    modport source (output valid, temp_centi, press_pa, hum_q10, fine_temp, input ready);
    modport sink (input valid, temp_centi, press_pa, hum_q10, fine_temp, output ready);
endinterface

interface esc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [esc_pkg::CFG_IDX_W-1:0]  index;
    logic [esc_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/esc_front.sv =====
`default_nettype none
module esc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire esc_pkg::t_trim i_trim,
    esc_in_if.sink             i_in,
    output logic               o_q_valid,
    output esc_pkg::t_mid      o_q_data,
    input  wire logic          i_q_ready
);

    logic [4:0]  r_fv;
    logic        en_f;
    logic [19:0] r0_at, r0_ap, r1_ap, r2_ap, r3_ap, r4_ap;
    logic [15:0] r0_ah, r1_ah, r2_ah, r3_ah, r4_ah;
    logic [31:0] r1_a, r1_d, r2_m1, r2_dd, r3_v1, r3_m2, r4_fine;
    logic [31:0] temp_sum;

    // pipeline moves whenever its last stage can leave
    assign en_f       = !r_fv[4] || i_q_ready;
    assign i_in.ready = en_f;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en_f) begin
            r_fv <= {r_fv[3:0], i_in.valid};
        end
    end

    // fine temperature datapath
    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r0_at   <= i_in.raw_temp;
            r0_ap   <= i_in.raw_press;
            r0_ah   <= i_in.raw_hum;
            r1_a    <= ({12'd0, r0_at} >> 3) - (i_trim.t1 << 1);
            r1_d    <= ({12'd0, r0_at} >> 4) - i_trim.t1;
            r1_ap   <= r0_ap;
            r1_ah   <= r0_ah;
            r2_m1   <= r1_a * i_trim.t2;
            r2_dd   <= r1_d * r1_d;
            r2_ap   <= r1_ap;
            r2_ah   <= r1_ah;
            r3_v1   <= esc_pkg::asr(r2_m1, 5'd11);
            r3_m2   <= esc_pkg::asr(r2_dd, 5'd12) * i_trim.t3;
            r3_ap   <= r2_ap;
            r3_ah   <= r2_ah;
            r4_fine <= r3_v1 + esc_pkg::asr(r3_m2, 5'd14);
            r4_ap   <= r3_ap;
            r4_ah   <= r3_ah;
        end
    end

    // temperature from fine: times five plus rounding
    assign temp_sum = (r4_fine << 2) + r4_fine + esc_pkg::K_128;

    assign o_q_valid     = r_fv[4];
    assign o_q_data.temp = esc_pkg::asr(temp_sum, 5'd8);
    assign o_q_data.fine = r4_fine;
    assign o_q_data.ap   = r4_ap;
    assign o_q_data.ah   = r4_ah;

endmodule
`default_nettype wire

// ===== design/esc_queue.sv =====
`default_nettype none
module esc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  wire esc_pkg::t_mid i_push_data,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output esc_pkg::t_mid      o_pop_data,
    input  wire logic          i_pop
);

    esc_pkg::t_mid                     r_mem [esc_pkg::QUEUE_DEPTH];
    logic [esc_pkg::QUEUE_PTR_W-1:0]   r_wr, r_rd;
    logic [esc_pkg::QUEUE_CNT_W-1:0]   r_cnt;
    logic                              push, pop;

    function automatic logic [esc_pkg::QUEUE_CNT_W-1:0] QUEUE_CNT_ONE(input logic b);
        QUEUE_CNT_ONE = {{(esc_pkg::QUEUE_CNT_W-1){1'b0}}, b};
    endfunction

    assign o_push_ready = (r_cnt != (esc_pkg::QUEUE_CNT_W)'(esc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QUEUE_CNT_ONE(push) - QUEUE_CNT_ONE(pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push_data;
    end

endmodule
`default_nettype wire

// ===== design/esc_div.sv =====
`default_nettype none
module esc_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [31:0]    i_num,
    input  wire logic [31:0]    i_den,
    input  wire esc_pkg::t_side i_side,
    output logic                o_valid,
    output logic [31:0]         o_quo,
    output esc_pkg::t_side      o_side
);

    localparam int N = esc_pkg::DIV_STEPS;

    logic [N:0]     r_v;
    logic [31:0]    r_rem  [N+1];
    logic [31:0]    r_nq   [N+1];
    logic [31:0]    r_den  [N+1];
    esc_pkg::t_side r_side [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= i_num;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [32:0] sh, diff;
        always_comb begin
            sh   = {r_rem[k], r_nq[k][31]};
            diff = sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= diff[32] ? sh[31:0] : diff[31:0];
                r_nq[k+1]   <= {r_nq[k][30:0], !diff[32]};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quo   = r_nq[N];
    assign o_side  = r_side[N];

endmodule
`default_nettype wire

// ===== design/esc_back.sv =====
`default_nettype none
module esc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire esc_pkg::t_trim i_trim,
    input  wire logic           i_q_valid,
    input  wire esc_pkg::t_mid  i_q_data,
    output logic                o_q_pop,
    esc_out_if.source           o_out
);

    logic        en_b;
    logic [8:0]  r_bv;
    logic [2:0]  r_pv;
    logic        r_ov;

    logic [31:0] r_temp [8];
    logic [31:0] r_fine [8];
    logic [19:0] r0_ap, r1_ap, r2_ap, r3_ap, r4_ap;
    logic [15:0] r0_ah, r1_ah, r2_ah;

    logic [31:0] r1_pv1, r1_hv;
    logic [31:0] r2_qq, r2_v1p5, r2_p2v1, r2_h5v, r2_vh6, r2_vh3;
    logic [31:0] r3_v2a, r3_p3m, r3_v1p5, r3_p2v1, r3_ha, r3_bb;
    logic [31:0] r4_v2, r4_x, r4_ha, r4_b2;
    logic [31:0] r5_y, r5_nb, r5_hv1;
    logic [31:0] r6_den, r6_pm, r6_hqq, r6_hv1;
    logic [31:0] r7_num, r7_den, r7_ht, r7_hv1;
    logic        r7_dbl;
    logic [31:0] r8_num, r8_den;
    esc_pkg::t_side r8_side;

    logic [31:0] q1, q5, hb, hd, hx;
    logic [16:0] hum;

    logic           d_valid;
    logic [31:0]    d_quo;
    esc_pkg::t_side d_side;

    logic [31:0]    r_p0_press, r_p1_press, r_p2_press;
    logic [31:0]    r_p1_sq, r_p1_p8, r_p2_p8, r_p2_p9;
    esc_pkg::t_side r_p0_side, r_p1_side, r_p2_side;
    logic [31:0]    p0_q, p2_corr, p2_press;

    // whole back pipeline advances when the output register is free
    assign en_b    = !r_ov || o_out.ready;
    assign o_q_pop = en_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_pv <= '0;
            r_ov <= 1'b0;
        end else if (en_b) begin
            r_bv <= {r_bv[7:0], i_q_valid};
            r_pv <= {r_pv[1:0], d_valid};
            r_ov <= r_pv[2];
        end
    end

    // pass-through of temperature and fine temperature
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_temp[0] <= i_q_data.temp;
            r_fine[0] <= i_q_data.fine;
            for (int k = 1; k < 8; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_fine[k] <= r_fine[k-1];
            end
        end
    end

    assign q1 = esc_pkg::asr(r1_pv1, 5'd2);
    assign hb = esc_pkg::asr(r4_b2 + esc_pkg::K_8192, 5'd14);
    assign q5 = esc_pkg::asr(r5_hv1, 5'd15);

    // pressure divisor, dividend and humidity terms
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r0_ap   <= i_q_data.ap;
            r0_ah   <= i_q_data.ah;

            r1_pv1  <= esc_pkg::asr(r_fine[0], 5'd1) - esc_pkg::K_64000;
            r1_hv   <= r_fine[0] - esc_pkg::K_76800;
            r1_ap   <= r0_ap;
            r1_ah   <= r0_ah;

            r2_qq   <= q1 * q1;
            r2_v1p5 <= r1_pv1 * i_trim.p5;
            r2_p2v1 <= i_trim.p2 * r1_pv1;
            r2_h5v  <= i_trim.h5 * r1_hv;
            r2_vh6  <= r1_hv * i_trim.h6;
            r2_vh3  <= r1_hv * i_trim.h3;
            r2_ap   <= r1_ap;
            r2_ah   <= r1_ah;

            r3_v2a  <= esc_pkg::asr(r2_qq, 5'd11) * i_trim.p6;
            r3_p3m  <= i_trim.p3 * esc_pkg::asr(r2_qq, 5'd13);
            r3_v1p5 <= r2_v1p5;
            r3_p2v1 <= r2_p2v1;
            r3_ha   <= esc_pkg::asr(({16'd0, r2_ah} << 14) - (i_trim.h4 << 20) - r2_h5v
                                    + esc_pkg::K_16384, 5'd15);
            r3_bb   <= esc_pkg::asr(r2_vh6, 5'd10)
                       * (esc_pkg::asr(r2_vh3, 5'd11) + esc_pkg::K_32768);
            r3_ap   <= r2_ap;

            r4_v2   <= esc_pkg::asr(r3_v2a + (r3_v1p5 << 1), 5'd2) + (i_trim.p4 << 16);
            r4_x    <= esc_pkg::asr(esc_pkg::asr(r3_p3m, 5'd3)
                                    + esc_pkg::asr(r3_p2v1, 5'd1), 5'd18);
            r4_ha   <= r3_ha;
            r4_b2   <= (esc_pkg::asr(r3_bb, 5'd10) + esc_pkg::K_2097152) * i_trim.h2;
            r4_ap   <= r3_ap;

            r5_y    <= (esc_pkg::K_32768 + r4_x) * i_trim.p1;
            r5_nb   <= (esc_pkg::K_1048576 - {12'd0, r4_ap}) - esc_pkg::asr(r4_v2, 5'd12);
            r5_hv1  <= r4_ha * hb;

            r6_den  <= esc_pkg::asr(r5_y, 5'd15);
            r6_pm   <= r5_nb * esc_pkg::K_3125;
            r6_hqq  <= q5 * q5;
            r6_hv1  <= r5_hv1;

            // large dividends are divided first and doubled after
            r7_dbl  <= (r6_pm >= esc_pkg::K_SIGN);
            r7_num  <= (r6_pm >= esc_pkg::K_SIGN) ? r6_pm : (r6_pm << 1);
            r7_den  <= r6_den;
            r7_ht   <= esc_pkg::asr(r6_hqq, 5'd7) * i_trim.h1;
            r7_hv1  <= r6_hv1;

            r8_num        <= r7_num;
            r8_den        <= r7_den;
            r8_side.temp  <= r_temp[7];
            r8_side.fine  <= r_fine[7];
            r8_side.hum   <= hum;
            r8_side.dbl   <= r7_dbl;
            r8_side.dzero <= (r7_den == '0);
        end
    end

    // humidity clamp and final scaling
    always_comb begin
        hd = r7_hv1 - esc_pkg::asr(r7_ht, 5'd4);
        priority if (hd[31]) begin
            hx = '0;
        end else if (hd > esc_pkg::K_HUM_MAX) begin
            hx = esc_pkg::K_HUM_MAX;
        end else begin
            hx = hd;
        end
        hum = hx[28:12];
    end

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_b),
        .i_valid (r_bv[8]),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    assign p0_q    = d_side.dbl ? {d_quo[30:0], 1'b0} : d_quo;
    assign p2_corr = esc_pkg::asr(esc_pkg::asr(r_p2_p9, 5'd12)
                                  + esc_pkg::asr(r_p2_p8, 5'd13) + i_trim.p7, 5'd4);
    assign p2_press = r_p2_side.dzero ? '0 : (r_p2_press + p2_corr);

    // pressure correction after the divider
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_p0_press <= p0_q;
            r_p0_side  <= d_side;
            r_p1_sq    <= {3'd0, r_p0_press[31:3]} * {3'd0, r_p0_press[31:3]};
            r_p1_p8    <= {2'd0, r_p0_press[31:2]} * i_trim.p8;
            r_p1_press <= r_p0_press;
            r_p1_side  <= r_p0_side;
            r_p2_p9    <= i_trim.p9 * {13'd0, r_p1_sq[31:13]};
            r_p2_p8    <= r_p1_p8;
            r_p2_press <= r_p1_press;
            r_p2_side  <= r_p1_side;
            o_out.temp_centi <= $signed(r_p2_side.temp);
            o_out.press_pa   <= p2_press;
            o_out.hum_q10    <= r_p2_side.hum;
            o_out.fine_temp  <= $signed(r_p2_side.fine);
        end
    end

    assign o_out.valid = r_ov;

endmodule
`default_nettype wire

// ===== design/env_sensor_compensation.sv =====
// throughput: one transaction per cycle while the output is not stalled
// the 32-stage pipelined divider sets the depth
// a 4-entry queue between the temperature front and the pressure/humidity back
// lets the input side keep accepting while the output is stalled, until the queue fills
// reset: synchronous active-low i_rst_n clears all valids, the queue and the trim registers
`default_nettype none
module env_sensor_compensation (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    esc_in_if.sink     i_in,
    esc_cfg_if.sink    i_cfg,
    esc_out_if.source  o_out
);

    logic [47:0] r_temp_trim, r_press_trim_a, r_press_trim_b, r_press_trim_c;
    logic [31:0] r_hum_trim_a;
    logic [39:0] r_hum_trim_b;
    esc_pkg::t_trim trim;

    logic          f_valid, f_ready, b_valid, b_pop;
    esc_pkg::t_mid f_data, b_data;

    assign i_cfg.ready = 1'b1;

    // trim register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim    <= '0;
            r_press_trim_a <= '0;
            r_press_trim_b <= '0;
            r_press_trim_c <= '0;
            r_hum_trim_a   <= '0;
            r_hum_trim_b   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                esc_pkg::CFG_TEMP_TRIM:    r_temp_trim    <= i_cfg.data;
                esc_pkg::CFG_PRESS_TRIM_A: r_press_trim_a <= i_cfg.data;
                esc_pkg::CFG_PRESS_TRIM_B: r_press_trim_b <= i_cfg.data;
                esc_pkg::CFG_PRESS_TRIM_C: r_press_trim_c <= i_cfg.data;
                esc_pkg::CFG_HUM_TRIM_A:   r_hum_trim_a   <= i_cfg.data[31:0];
                esc_pkg::CFG_HUM_TRIM_B:   r_hum_trim_b   <= i_cfg.data[39:0];
                default: ;
            endcase
        end
    end

    // trim unpacking
    always_comb begin
        trim.t1 = {16'd0, r_temp_trim[15:0]};
        trim.t2 = esc_pkg::sx16(r_temp_trim[31:16]);
        trim.t3 = esc_pkg::sx16(r_temp_trim[47:32]);
        trim.p1 = {16'd0, r_press_trim_a[15:0]};
        trim.p2 = esc_pkg::sx16(r_press_trim_a[31:16]);
        trim.p3 = esc_pkg::sx16(r_press_trim_a[47:32]);
        trim.p4 = esc_pkg::sx16(r_press_trim_b[15:0]);
        trim.p5 = esc_pkg::sx16(r_press_trim_b[31:16]);
        trim.p6 = esc_pkg::sx16(r_press_trim_b[47:32]);
        trim.p7 = esc_pkg::sx16(r_press_trim_c[15:0]);
        trim.p8 = esc_pkg::sx16(r_press_trim_c[31:16]);
        trim.p9 = esc_pkg::sx16(r_press_trim_c[47:32]);
        trim.h1 = {24'd0, r_hum_trim_a[7:0]};
        trim.h2 = esc_pkg::sx16(r_hum_trim_a[23:8]);
        trim.h3 = {24'd0, r_hum_trim_a[31:24]};
        trim.h4 = esc_pkg::sx16(r_hum_trim_b[15:0]);
        trim.h5 = esc_pkg::sx16(r_hum_trim_b[31:16]);
        trim.h6 = esc_pkg::sx8(r_hum_trim_b[39:32]);
    end

    esc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_trim    (trim),
        .i_in      (i_in),
        .o_q_valid (f_valid),
        .o_q_data  (f_data),
        .i_q_ready (f_ready)
    );

    esc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_data),
        .o_push_ready (f_ready),
        .o_pop_valid  (b_valid),
        .o_pop_data   (b_data),
        .i_pop        (b_pop)
    );

    esc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_trim    (trim),
        .i_q_valid (b_valid),
        .i_q_data  (b_data),
        .o_q_pop   (b_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire
